/* rtl/cwr_pkg.sv */
// cwr_pkg: shared constants and types for the window-report parser.
// Used by cwr_step and csi_window_report_parser. No dependencies.
`timescale 1ns / 1ps

package cwr_pkg;

  // accumulator width default for height and width
  localparam int NUM_BITS_DEF = 16;

  // character codes
  localparam logic [15:0] CH_ESC  = 16'h001B;
  localparam logic [15:0] CH_LBR  = 16'h005B;
  localparam logic [15:0] CH_SEMI = 16'h003B;
  localparam logic [15:0] CH_T    = 16'h0074;
  localparam logic [15:0] CH_ZERO = 16'h0030;
  localparam logic [15:0] CH_NINE = 16'h0039;

  // parser phases
  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ESC  = 3'd1;
  localparam logic [2:0] PH_OP0  = 3'd2;
  localparam logic [2:0] PH_OP   = 3'd3;
  localparam logic [2:0] PH_H0   = 3'd4;
  localparam logic [2:0] PH_H    = 3'd5;
  localparam logic [2:0] PH_W0   = 3'd6;
  localparam logic [2:0] PH_W    = 3'd7;

  localparam logic [6:0]  OP_MAX          = 7'd127;
  localparam logic [5:0]  LEN_MAX         = 6'd63;
  localparam logic [15:0] OUT_MAX         = 16'hFFFF;
  localparam logic [6:0]  EXPECTED_OP_RST = 7'd4;

  // narrow parser state (accumulators for sizes travel separately)
  typedef struct packed {
    logic [2:0] phase;
    logic [6:0] op_acc;
    logic [5:0] len_count;
  } ctl_t;

  // one result
  typedef struct packed {
    logic        match;
    logic [15:0] height;
    logic [15:0] width;
    logic [5:0]  report_len;
  } res_t;

endpackage

/* rtl/csi_window_report_parser.sv */
// csi_window_report_parser: top level of the terminal window-size report scanner.
// Depends on cwr_pkg and cwr_step.
//
// Usage:
//  - Input channel s_axis_*: one 16-bit character per transaction.
//  - Output channel m_axis_*: exactly one result per input character.
//    m_axis_tuser is the match flag; tdata carries height, width and the
//    report length, all zero when there is no match.
//  - Config: cfg_we/cfg_wdata write expected_op (reset 4); write only while idle.
//  - Result: registered; each accepted input character writes its result into the output register.
//  - Throughput: one character per cycle while m_axis_tready is high. The parser state registers update
//    on each accepted character through a single pass of shift-add and
//    compare logic, so that logic does not limit the rate below that.
//  - Stall: the output register holds its result while m_axis_tready is low;
//    s_axis_tready stays high while the register is empty or being drained
//    in the same cycle, so a new character enters as the old result leaves.
//  - Reset (rst, synchronous): parser to idle, accumulators and length to zero,
//    output register empty, expected_op back to 4.
`timescale 1ns / 1ps

module csi_window_report_parser #(
  parameter int NUM_BITS = cwr_pkg::NUM_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input characters
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] ch
  // results
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [15:0] height, [31:16] width, [37:32] report_len
  output logic        m_axis_tuser,   // [0] match
  // configuration
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata       // expected_op
);

  logic [6:0]          expected_op;
  cwr_pkg::ctl_t       ctl;
  cwr_pkg::ctl_t       ctl_next;
  logic [NUM_BITS-1:0] height_acc;
  logic [NUM_BITS-1:0] height_acc_next;
  logic [NUM_BITS-1:0] width_acc;
  logic [NUM_BITS-1:0] width_acc_next;
  cwr_pkg::res_t       res_next;
  cwr_pkg::res_t       res;
  logic                out_valid;
  logic                in_fire;

  // output register free, or emptied this cycle
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_op <= cwr_pkg::EXPECTED_OP_RST;
    end else if (cfg_we) begin
      expected_op <= cfg_wdata;
    end
  end

  cwr_step #(
    .NUM_BITS(NUM_BITS)
  ) u_step (
    .ch              (s_axis_tdata),
    .expected_op     (expected_op),
    .cur             (ctl),
    .height_acc      (height_acc),
    .width_acc       (width_acc),
    .nxt             (ctl_next),
    .height_acc_next (height_acc_next),
    .width_acc_next  (width_acc_next),
    .res             (res_next)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl        <= '0;
      height_acc <= '0;
      width_acc  <= '0;
    end else if (in_fire) begin
      ctl        <= ctl_next;
      height_acc <= height_acc_next;
      width_acc  <= width_acc_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = res.match;
  assign m_axis_tdata  = {2'b00, res.report_len, res.width, res.height};

endmodule

/* rtl/cwr_step.sv */
// cwr_step: next-state and result logic for one character of the report parser.
// Depends on cwr_pkg.
`timescale 1ns / 1ps

module cwr_step #(
  parameter int NUM_BITS = cwr_pkg::NUM_BITS_DEF
) (
  input  logic [15:0]         ch,
  input  logic [6:0]          expected_op,
  input  cwr_pkg::ctl_t       cur,
  input  logic [NUM_BITS-1:0] height_acc,
  input  logic [NUM_BITS-1:0] width_acc,
  output cwr_pkg::ctl_t       nxt,
  output logic [NUM_BITS-1:0] height_acc_next,
  output logic [NUM_BITS-1:0] width_acc_next,
  output cwr_pkg::res_t       res
);

  logic                is_digit;
  logic [3:0]          digit;
  logic [5:0]          len_inc;
  logic [10:0]         op_mul;
  logic [6:0]          op_sat;
  logic [NUM_BITS+3:0] h_mul;
  logic [NUM_BITS+3:0] w_mul;
  logic [NUM_BITS-1:0] h_sat;
  logic [NUM_BITS-1:0] w_sat;
  logic [15:0]         h_out;
  logic [15:0]         w_out;
  logic                hit;
  logic                consumed;

  assign is_digit = (ch >= cwr_pkg::CH_ZERO) && (ch <= cwr_pkg::CH_NINE);
  // low nibble of '0'..'9' is the digit value
  assign digit    = ch[3:0];
  assign len_inc  = (cur.len_count == cwr_pkg::LEN_MAX) ? cwr_pkg::LEN_MAX
                                                        : cur.len_count + 6'd1;

  // acc * 10 + digit as shift-add, saturating
  assign op_mul = ({4'b0, cur.op_acc} << 3) + ({4'b0, cur.op_acc} << 1) + {7'b0, digit};
  assign op_sat = (op_mul > {4'b0, cwr_pkg::OP_MAX}) ? cwr_pkg::OP_MAX : op_mul[6:0];

  assign h_mul = ({4'b0, height_acc} << 3) + ({4'b0, height_acc} << 1)
               + (NUM_BITS+4)'(digit);
  assign w_mul = ({4'b0, width_acc} << 3) + ({4'b0, width_acc} << 1)
               + (NUM_BITS+4)'(digit);
  assign h_sat = (h_mul[NUM_BITS+3:NUM_BITS] != 4'd0) ? '1 : h_mul[NUM_BITS-1:0];
  assign w_sat = (w_mul[NUM_BITS+3:NUM_BITS] != 4'd0) ? '1 : w_mul[NUM_BITS-1:0];

  // clamp to the 16-bit result fields
  assign h_out = (height_acc > NUM_BITS'(cwr_pkg::OUT_MAX)) ? cwr_pkg::OUT_MAX
                                                             : 16'(height_acc);
  assign w_out = (width_acc > NUM_BITS'(cwr_pkg::OUT_MAX)) ? cwr_pkg::OUT_MAX
                                                            : 16'(width_acc);

  always_comb begin
    nxt             = cur;
    height_acc_next = height_acc;
    width_acc_next  = width_acc;
    res             = '0;
    hit             = 1'b0;
    consumed        = 1'b0;

    if (ch == cwr_pkg::CH_ESC) begin
      // ESC restarts the sequence from anywhere
      nxt.phase       = cwr_pkg::PH_ESC;
      nxt.op_acc      = '0;
      nxt.len_count   = 6'd1;
      height_acc_next = '0;
      width_acc_next  = '0;
    end else if (cur.phase != cwr_pkg::PH_IDLE) begin
      nxt.len_count = len_inc;
      case (cur.phase)
        cwr_pkg::PH_ESC: begin
          if (ch == cwr_pkg::CH_LBR) begin
            nxt.phase = cwr_pkg::PH_OP0;
            consumed  = 1'b1;
          end
        end
        cwr_pkg::PH_OP0, cwr_pkg::PH_OP: begin
          if (is_digit) begin
            nxt.op_acc = op_sat;
            nxt.phase  = cwr_pkg::PH_OP;
            consumed   = 1'b1;
          end else if (cur.phase == cwr_pkg::PH_OP && ch == cwr_pkg::CH_SEMI) begin
            nxt.phase = cwr_pkg::PH_H0;
            consumed  = 1'b1;
          end
        end
        cwr_pkg::PH_H0, cwr_pkg::PH_H: begin
          if (is_digit) begin
            height_acc_next = h_sat;
            nxt.phase       = cwr_pkg::PH_H;
            consumed        = 1'b1;
          end else if (cur.phase == cwr_pkg::PH_H && ch == cwr_pkg::CH_SEMI) begin
            nxt.phase = cwr_pkg::PH_W0;
            consumed  = 1'b1;
          end
        end
        cwr_pkg::PH_W0, cwr_pkg::PH_W: begin
          if (is_digit) begin
            width_acc_next = w_sat;
            nxt.phase      = cwr_pkg::PH_W;
            consumed       = 1'b1;
          end else if (cur.phase == cwr_pkg::PH_W && ch == cwr_pkg::CH_T) begin
            hit = (cur.op_acc == expected_op) && (height_acc != '0) && (width_acc != '0);
          end
        end
        default: begin
          consumed = 1'b0;
        end
      endcase

      // sequence ended or broken: back to idle
      if (!consumed) begin
        nxt             = '0;
        height_acc_next = '0;
        width_acc_next  = '0;
      end
      if (hit) begin
        res.match      = 1'b1;
        res.height     = h_out;
        res.width      = w_out;
        res.report_len = len_inc;
      end
    end
  end

endmodule

/* rtl/cwr_checker.sv */
// cwr_checker: port-level assertions for csi_window_report_parser, bound to it.
// No package dependencies.
`timescale 1ns / 1ps

module cwr_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // shortest report: ESC [ d ; d ; d t
  localparam logic [5:0] MIN_REPORT_LEN = 6'd8;

  // no match means an all-zero payload
  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 40'd0))
    else $error("nonzero payload without match");

  // a match carries nonzero sizes and a plausible length
  a_match_fields: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |->
      (m_axis_tdata[15:0] != 16'd0) && (m_axis_tdata[31:16] != 16'd0) &&
      (m_axis_tdata[37:32] >= MIN_REPORT_LEN))
    else $error("match with bad fields");

  // input side never blocked while output register is empty
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed under stall");

endmodule

bind csi_window_report_parser cwr_checker u_cwr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
